// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TPFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TPFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/tpfd_pkg.sv =====
// Package: types, constants and control store of the payload field decoder.
package tpfd_pkg;

  localparam int unsigned PAYLOAD_BYTES = 16;
  localparam int unsigned STORE_BITS    = PAYLOAD_BYTES * 8;
  localparam int unsigned IDX_W         = $clog2(PAYLOAD_BYTES);
  localparam int unsigned CNT_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned OFS_W         = 7;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned RAW_W         = 22;
  localparam int unsigned VAL_W         = 23;
  localparam int unsigned CODE_W        = 5;
  localparam int unsigned STEP_W        = 5;

  localparam logic [7:0] RT_SOLAR   = 8'd1;
  localparam logic [7:0] RT_MONITOR = 8'd2;
  localparam logic [7:0] RT_INVERT  = 8'd3;
  localparam logic [7:0] RT_DCDC    = 8'd4;
  localparam logic [7:0] RT_CHARGER = 8'd8;

  typedef enum logic [CODE_W-1:0] {
    FC_NONE     = 5'd0,
    FC_STATE    = 5'd1,
    FC_ERROR    = 5'd2,
    FC_BATT_V   = 5'd3,
    FC_BATT_I   = 5'd4,
    FC_YIELD    = 5'd5,
    FC_PV_W     = 5'd6,
    FC_REM_MIN  = 5'd7,
    FC_CONSUMED = 5'd8,
    FC_SOC      = 5'd9,
    FC_AUX_MODE = 5'd10,
    FC_AUX_V    = 5'd11,
    FC_TEMP     = 5'd12,
    FC_ALARM    = 5'd13,
    FC_AC_VA    = 5'd14,
    FC_AC_V     = 5'd15,
    FC_AC_I     = 5'd16,
    FC_IN_V     = 5'd17,
    FC_OUT_V    = 5'd18
  } fcode_e;

  // not-available check applied to the raw field
  typedef enum logic [1:0] {
    SN_NONE,    // always valid
    SN_ONES,    // all ones
    SN_MAXPOS,  // largest positive signed value
    SN_NEVER    // never valid
  } sent_e;

  typedef enum logic [2:0] {
    SC_NONE,
    SC_X100,
    SC_NEG,
    SC_K2C,     // minus 27315
    SC_OFS40    // (v - 40) * 100
  } scale_e;

  typedef enum logic [1:0] {
    NX_SEQ,
    NX_AUX,     // branch on aux mode
    NX_END
  } nxt_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXTRACT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic [LEN_W-1:0] len;
    logic             sgn;
    fcode_e           code;
    sent_e            sent;
    scale_e           scale;
    nxt_e             nxt;
  } uword_t;

  localparam logic [STEP_W-1:0] EP_NONE    = 5'd0;
  localparam logic [STEP_W-1:0] EP_SOLAR   = 5'd1;
  localparam logic [STEP_W-1:0] EP_MONITOR = 5'd7;
  localparam logic [STEP_W-1:0] EP_AUX_V   = 5'd13;
  localparam logic [STEP_W-1:0] EP_TEMP    = 5'd14;
  localparam logic [STEP_W-1:0] EP_AUX_NA  = 5'd15;
  localparam logic [STEP_W-1:0] EP_INVERT  = 5'd16;
  localparam logic [STEP_W-1:0] EP_DCDC    = 5'd22;
  localparam logic [STEP_W-1:0] EP_CHARGER = 5'd26;

  function automatic uword_t uw(int unsigned offset, int unsigned len, logic sgn,
                                fcode_e code, sent_e sent, scale_e scale, nxt_e nxt);
    uword_t w;
    w.offset = OFS_W'(offset);
    w.len    = LEN_W'(len);
    w.sgn    = sgn;
    w.code   = code;
    w.sent   = sent;
    w.scale  = scale;
    w.nxt    = nxt;
    return w;
  endfunction

  function automatic uword_t ucode(logic [STEP_W-1:0] addr);
    uword_t w;
    unique case (addr)
      5'd0:  w = uw(0,   1,  1'b0, FC_NONE,     SN_NEVER,  SC_NONE,  NX_END);
      // solar
      5'd1:  w = uw(0,   8,  1'b0, FC_STATE,    SN_NONE,   SC_NONE,  NX_SEQ);
      5'd2:  w = uw(8,   8,  1'b0, FC_ERROR,    SN_NONE,   SC_NONE,  NX_SEQ);
      5'd3:  w = uw(16,  16, 1'b1, FC_BATT_V,   SN_MAXPOS, SC_NONE,  NX_SEQ);
      5'd4:  w = uw(32,  16, 1'b1, FC_BATT_I,   SN_MAXPOS, SC_X100,  NX_SEQ);
      5'd5:  w = uw(48,  16, 1'b0, FC_YIELD,    SN_ONES,   SC_NONE,  NX_SEQ);
      5'd6:  w = uw(64,  16, 1'b0, FC_PV_W,     SN_ONES,   SC_NONE,  NX_END);
      // battery monitor
      5'd7:  w = uw(0,   16, 1'b0, FC_REM_MIN,  SN_ONES,   SC_NONE,  NX_SEQ);
      5'd8:  w = uw(16,  16, 1'b1, FC_BATT_V,   SN_MAXPOS, SC_NONE,  NX_SEQ);
      5'd9:  w = uw(66,  22, 1'b1, FC_BATT_I,   SN_MAXPOS, SC_NONE,  NX_SEQ);
      5'd10: w = uw(88,  20, 1'b0, FC_CONSUMED, SN_ONES,   SC_NEG,   NX_SEQ);
      5'd11: w = uw(108, 10, 1'b0, FC_SOC,      SN_ONES,   SC_NONE,  NX_SEQ);
      5'd12: w = uw(64,  2,  1'b0, FC_AUX_MODE, SN_NONE,   SC_NONE,  NX_AUX);
      5'd13: w = uw(48,  16, 1'b1, FC_AUX_V,    SN_MAXPOS, SC_NONE,  NX_END);
      5'd14: w = uw(48,  16, 1'b0, FC_TEMP,     SN_ONES,   SC_K2C,   NX_END);
      5'd15: w = uw(48,  1,  1'b0, FC_AUX_V,    SN_NEVER,  SC_NONE,  NX_END);
      // inverter
      5'd16: w = uw(0,   8,  1'b0, FC_STATE,    SN_NONE,   SC_NONE,  NX_SEQ);
      5'd17: w = uw(8,   16, 1'b0, FC_ALARM,    SN_NONE,   SC_NONE,  NX_SEQ);
      5'd18: w = uw(24,  16, 1'b1, FC_BATT_V,   SN_MAXPOS, SC_NONE,  NX_SEQ);
      5'd19: w = uw(40,  16, 1'b0, FC_AC_VA,    SN_ONES,   SC_NONE,  NX_SEQ);
      5'd20: w = uw(56,  15, 1'b0, FC_AC_V,     SN_ONES,   SC_NONE,  NX_SEQ);
      5'd21: w = uw(71,  11, 1'b0, FC_AC_I,     SN_ONES,   SC_NONE,  NX_END);
      // dc-dc
      5'd22: w = uw(0,   8,  1'b0, FC_STATE,    SN_NONE,   SC_NONE,  NX_SEQ);
      5'd23: w = uw(8,   8,  1'b0, FC_ERROR,    SN_NONE,   SC_NONE,  NX_SEQ);
      5'd24: w = uw(16,  16, 1'b0, FC_IN_V,     SN_ONES,   SC_NONE,  NX_SEQ);
      5'd25: w = uw(32,  16, 1'b1, FC_OUT_V,    SN_MAXPOS, SC_NONE,  NX_END);
      // ac charger
      5'd26: w = uw(0,   8,  1'b0, FC_STATE,    SN_NONE,   SC_NONE,  NX_SEQ);
      5'd27: w = uw(8,   8,  1'b0, FC_ERROR,    SN_NONE,   SC_NONE,  NX_SEQ);
      5'd28: w = uw(16,  13, 1'b0, FC_BATT_V,   SN_ONES,   SC_NONE,  NX_SEQ);
      5'd29: w = uw(29,  11, 1'b0, FC_BATT_I,   SN_ONES,   SC_X100,  NX_SEQ);
      5'd30: w = uw(88,  7,  1'b0, FC_TEMP,     SN_ONES,   SC_OFS40, NX_END);
      default: w = uw(0, 1,  1'b0, FC_NONE,     SN_NEVER,  SC_NONE,  NX_END);
    endcase
    return w;
  endfunction

  function automatic logic [STEP_W-1:0] entry_point(logic [7:0] rtype);
    logic [STEP_W-1:0] ep;
    unique case (rtype)
      RT_SOLAR:   ep = EP_SOLAR;
      RT_MONITOR: ep = EP_MONITOR;
      RT_INVERT:  ep = EP_INVERT;
      RT_DCDC:    ep = EP_DCDC;
      RT_CHARGER: ep = EP_CHARGER;
      default:    ep = EP_NONE;
    endcase
    return ep;
  endfunction

endpackage

// ===== hdl/tpfd_if.sv =====
// Item channel interfaces: payload byte input and decoded field output.
interface tpfd_in_if import tpfd_pkg::*;;
  logic       valid;
  logic       ready;
  logic       first_byte;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [7:0] record_type;

  modport source (output valid, first_byte, data_byte, last_byte, record_type,
                  input ready);
  modport sink   (input valid, first_byte, data_byte, last_byte, record_type,
                  output ready);
endinterface

interface tpfd_out_if import tpfd_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CODE_W-1:0]       field_code;
  logic signed [VAL_W-1:0] field_value;
  logic                    field_valid;
  logic                    last_field;

  modport source (output valid, field_code, field_value, field_valid, last_field,
                  input ready);
  modport sink   (input valid, field_code, field_value, field_valid, last_field,
                  output ready);
endinterface

// ===== hdl/telemetry_payload_field_decoder_unit.sv =====
// Top level: telemetry payload field decoder driven by a microcoded sequencer.
//
// in_i carries one payload byte per item, packed LSB first. first_byte clears
// the 16-byte store and the byte count before the byte is stored; bytes past
// the store size are dropped. Unwritten bits read as zero.
// An item with last_byte set starts decoding of record_type. The sequencer
// walks a control store, one control word per field: an extract step pulls the
// bit field out of the store, an emit step scales, checks and loads the output
// register. A record gives 1 to 7 fields on out_o, last_field marking the final
// one. Bytes without last_byte are taken every cycle while the sequencer is idle.
// in_i.ready is low while the sequencer runs; it rises as soon as the final field
// sits in the output register, so the next record's bytes may flow while that
// field waits. A stall on out_o holds the sequencer in the emit step; nothing is
// dropped. Unsupported record types give one field with code 0 and last_field
// set. Reset clears the store, the byte count, the sequencer and out_o.valid.
module telemetry_payload_field_decoder_unit import tpfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpfd_in_if.sink    in_i,
  tpfd_out_if.source out_o
);

  state_e                      state_q, state_d;
  logic [STEP_W-1:0]           step_q, step_d;
  logic [PAYLOAD_BYTES-1:0][7:0] store_q;
  logic [CNT_W-1:0]            count_q;
  logic [RAW_W-1:0]            raw_q;
  logic                        out_valid_q;
  logic [CODE_W-1:0]           code_q;
  logic signed [VAL_W-1:0]     value_q;
  logic                        fvalid_q;
  logic                        flast_q;

  uword_t                  uw_cur;
  logic                    in_acc;
  logic                    load_out;
  logic [STORE_BITS-1:0]   shifted;
  logic [RAW_W:0]          mask_ext;
  logic [RAW_W-1:0]        mask;
  logic [RAW_W-1:0]        raw_sel;
  logic [LEN_W-1:0]        sign_idx;
  logic                    sbit;
  logic signed [VAL_W-1:0] sval;
  logic signed [VAL_W-1:0] pre;
  logic signed [VAL_W-1:0] prod;
  logic signed [VAL_W-1:0] scaled;
  logic                    fld_ok;

  assign uw_cur = ucode(step_q);
  assign in_acc = in_i.valid && in_i.ready;

  // datapath
  assign mask_ext = (VAL_W'(1) << uw_cur.len) - VAL_W'(1);
  assign mask     = mask_ext[RAW_W-1:0];
  assign shifted  = store_q >> uw_cur.offset;
  assign raw_sel  = shifted[RAW_W-1:0] & mask;
  assign sign_idx = uw_cur.len - LEN_W'(1);
  assign sbit     = uw_cur.sgn && raw_q[sign_idx];
  assign sval     = sbit ? {1'b1, raw_q | ~mask} : {1'b0, raw_q};
  assign pre      = (uw_cur.scale == SC_OFS40) ? sval - VAL_W'(40) : sval;
  assign prod     = pre * VAL_W'(100);

  always_comb begin
    case (uw_cur.scale)
      SC_X100, SC_OFS40: scaled = prod;
      SC_NEG:            scaled = -sval;
      SC_K2C:            scaled = sval - VAL_W'(27315);
      default:           scaled = sval;
    endcase
  end

  always_comb begin
    unique case (uw_cur.sent)
      SN_NONE:   fld_ok = 1'b1;
      SN_ONES:   fld_ok = (raw_q != mask);
      SN_MAXPOS: fld_ok = (raw_q != (mask >> 1));
      default:   fld_ok = 1'b0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= EP_NONE;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    load_out   = 1'b0;
    in_i.ready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid && in_i.last_byte) begin
          state_d = ST_EXTRACT;
          step_d  = entry_point(in_i.record_type);
        end
      end
      ST_EXTRACT: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_EXTRACT;
          unique case (uw_cur.nxt)
            NX_END: state_d = ST_IDLE;
            NX_AUX: begin
              case (raw_q[1:0])
                2'd2:    step_d = EP_TEMP;
                2'd3:    step_d = EP_AUX_NA;
                default: step_d = EP_AUX_V;
              endcase
            end
            default: step_d = step_q + STEP_W'(1);
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // byte store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      count_q <= '0;
    end else if (in_acc) begin
      if (in_i.first_byte) begin
        store_q <= STORE_BITS'(in_i.data_byte);
        count_q <= CNT_W'(1);
      end else if (count_q < CNT_W'(PAYLOAD_BYTES)) begin
        store_q[count_q[IDX_W-1:0]] <= in_i.data_byte;
        count_q                     <= count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXTRACT) begin
      raw_q <= raw_sel;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      code_q   <= uw_cur.code;
      value_q  <= fld_ok ? scaled : '0;
      fvalid_q <= fld_ok;
      flast_q  <= (uw_cur.nxt == NX_END);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.field_code  = code_q;
  assign out_o.field_value = value_q;
  assign out_o.field_valid = fvalid_q;
  assign out_o.last_field  = flast_q;

endmodule

// ===== hdl/tpfd_checker.sv =====
// Port-level checker for the payload field decoder, bound to the top level.
`include "assert_macros.svh"

module tpfd_checker import tpfd_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    in_last_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [CODE_W-1:0]       field_code_i,
  input logic signed [VAL_W-1:0] field_value_i,
  input logic                    field_valid_i,
  input logic                    last_field_i
);

  `TPFD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(field_code_i) && $stable(field_value_i))
  `TPFD_ASSERT_NEXT(a_busy_after_last, in_valid_i && in_ready_i && in_last_i, !in_ready_i)
  `TPFD_ASSERT_NOW(a_invalid_zero, out_valid_i && !field_valid_i, field_value_i == '0)
  `TPFD_ASSERT_NOW(a_code_range, out_valid_i, field_code_i <= CODE_W'(FC_OUT_V))
  `TPFD_ASSERT_NOW(a_none_alone, out_valid_i && field_code_i == CODE_W'(FC_NONE),
    last_field_i && !field_valid_i)

endmodule

bind telemetry_payload_field_decoder_unit tpfd_checker u_tpfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_last_i     (in_i.last_byte),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .field_code_i  (out_o.field_code),
  .field_value_i (out_o.field_value),
  .field_valid_i (out_o.field_valid),
  .last_field_i  (out_o.last_field)
);

// ===== verif/tb_top.sv =====
// Testbench: payload field decoder driven with byte records, results checked in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tpfd_pkg::*;

  localparam int LIMIT = 400000;
  localparam int TAIL  = 40;

  typedef struct {
    logic       first;
    logic [7:0] data;
    logic       last;
    logic [7:0] rtype;
    int         phase;
    bit         drain;
  } byte_item_t;

  typedef struct {
    fcode_e                  code;
    logic signed [VAL_W-1:0] value;
    logic                    ok;
    logic                    last;
  } field_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tpfd_in_if  in_if ();
  tpfd_out_if out_if ();

  telemetry_payload_field_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always #5ns clk_i = ~clk_i;

  byte_item_t byte_q[$];
  field_t     fields_due[$];
  logic [7:0] rec_bytes [PAYLOAD_BYTES];
  int         rec_len      = 0;
  logic [7:0] draft [20];
  logic       in_took      = 1'b0;
  int         cur_phase    = 0;
  int         mismatches   = 0;
  int         bytes_taken  = 0;
  int         bytes_total  = 0;

  function automatic int idle_pct(int ph);
    case (ph)
      1:       return 53;
      3:       return 13;
      default: return 0;
    endcase
  endfunction

  function automatic int stall_pct(int ph);
    case (ph)
      2:       return 53;
      3:       return 13;
      default: return 0;
    endcase
  endfunction

  // ---------------- field predictor ----------------

  function automatic logic [31:0] pull(int off, int len);
    logic [31:0] v;
    int p;
    v = '0;
    for (int i = 0; i < len; i++) begin
      p = off + i;
      if ((p >> 3) < rec_len && rec_bytes[p >> 3][p & 7]) v[i] = 1'b1;
    end
    return v;
  endfunction

  function automatic int as_signed(logic [31:0] raw, int len);
    if (raw[len-1]) return int'(raw) - (1 << len);
    return int'(raw);
  endfunction

  function automatic void due_field(fcode_e code, int value, logic ok);
    field_t f;
    f.code  = code;
    f.value = ok ? VAL_W'(value) : '0;
    f.ok    = ok;
    f.last  = 1'b0;
    fields_due.push_back(f);
  endfunction

  function automatic void decode_record(logic [7:0] rtype);
    logic [31:0] raw, aux, mode;
    case (rtype)
      RT_SOLAR: begin
        due_field(FC_STATE, int'(pull(0, 8)), 1'b1);
        due_field(FC_ERROR, int'(pull(8, 8)), 1'b1);
        raw = pull(16, 16);
        due_field(FC_BATT_V, as_signed(raw, 16), raw != 32'h7FFF);
        raw = pull(32, 16);
        due_field(FC_BATT_I, as_signed(raw, 16) * 100, raw != 32'h7FFF);
        raw = pull(48, 16);
        due_field(FC_YIELD, int'(raw), raw != 32'hFFFF);
        raw = pull(64, 16);
        due_field(FC_PV_W, int'(raw), raw != 32'hFFFF);
      end
      RT_MONITOR: begin
        raw = pull(0, 16);
        due_field(FC_REM_MIN, int'(raw), raw != 32'hFFFF);
        raw = pull(16, 16);
        due_field(FC_BATT_V, as_signed(raw, 16), raw != 32'h7FFF);
        aux  = pull(48, 16);
        mode = pull(64, 2);
        raw = pull(66, 22);
        due_field(FC_BATT_I, as_signed(raw, 22), raw != 32'h1FFFFF);
        raw = pull(88, 20);
        due_field(FC_CONSUMED, -int'(raw), raw != 32'hFFFFF);
        raw = pull(108, 10);
        due_field(FC_SOC, int'(raw), raw != 32'h3FF);
        due_field(FC_AUX_MODE, int'(mode), 1'b1);
        if (mode < 2) due_field(FC_AUX_V, as_signed(aux, 16), aux != 32'h7FFF);
        else if (mode == 2) due_field(FC_TEMP, int'(aux) - 27315, aux != 32'hFFFF);
        else due_field(FC_AUX_V, 0, 1'b0);
      end
      RT_INVERT: begin
        due_field(FC_STATE, int'(pull(0, 8)), 1'b1);
        due_field(FC_ALARM, int'(pull(8, 16)), 1'b1);
        raw = pull(24, 16);
        due_field(FC_BATT_V, as_signed(raw, 16), raw != 32'h7FFF);
        raw = pull(40, 16);
        due_field(FC_AC_VA, int'(raw), raw != 32'hFFFF);
        raw = pull(56, 15);
        due_field(FC_AC_V, int'(raw), raw != 32'h7FFF);
        raw = pull(71, 11);
        due_field(FC_AC_I, int'(raw), raw != 32'h7FF);
      end
      RT_DCDC: begin
        due_field(FC_STATE, int'(pull(0, 8)), 1'b1);
        due_field(FC_ERROR, int'(pull(8, 8)), 1'b1);
        raw = pull(16, 16);
        due_field(FC_IN_V, int'(raw), raw != 32'hFFFF);
        raw = pull(32, 16);
        due_field(FC_OUT_V, as_signed(raw, 16), raw != 32'h7FFF);
      end
      RT_CHARGER: begin
        due_field(FC_STATE, int'(pull(0, 8)), 1'b1);
        due_field(FC_ERROR, int'(pull(8, 8)), 1'b1);
        raw = pull(16, 13);
        due_field(FC_BATT_V, int'(raw), raw != 32'h1FFF);
        raw = pull(29, 11);
        due_field(FC_BATT_I, int'(raw) * 100, raw != 32'h7FF);
        raw = pull(88, 7);
        due_field(FC_TEMP, (int'(raw) - 40) * 100, raw != 32'h7F);
      end
      default: due_field(FC_NONE, 0, 1'b0);
    endcase
    fields_due[$].last = 1'b1;
  endfunction

  function automatic void take_byte(logic first, logic [7:0] data, logic last,
                                    logic [7:0] rtype);
    if (first) begin
      foreach (rec_bytes[i]) rec_bytes[i] = 8'h00;
      rec_len = 0;
    end
    if (rec_len < PAYLOAD_BYTES) begin
      rec_bytes[rec_len] = data;
      rec_len++;
    end
    if (last) decode_record(rtype);
  endfunction

  // ---------------- stimulus building ----------------

  function automatic void put(logic first, logic [7:0] data, logic last, logic [7:0] rtype,
                              int ph, bit drain);
    byte_item_t it;
    it.first = first;
    it.data  = data;
    it.last  = last;
    it.rtype = rtype;
    it.phase = ph;
    it.drain = drain;
    byte_q.push_back(it);
  endfunction

  function automatic void send_draft(int n, logic [7:0] rt, bit mark_first, int ph, bit drain);
    for (int i = 0; i < n; i++)
      put(mark_first && i == 0, draft[i], i == n - 1,
          (i == n - 1) ? rt : 8'($urandom_range(0, 255)), ph, drain && i == 0);
  endfunction

  // one time in three, overwrite a field with all ones, the largest positive, zero or the sign bit alone
  function automatic void plant_pattern(int off, int len);
    int kind;
    int p;
    if ($urandom_range(0, 2) != 0) return;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      p = off + i;
      case (kind)
        0:       draft[p >> 3][p & 7] = 1'b1;
        1:       draft[p >> 3][p & 7] = (i != len - 1);
        2:       draft[p >> 3][p & 7] = 1'b0;
        default: draft[p >> 3][p & 7] = (i == len - 1);
      endcase
    end
  endfunction

  function automatic void gen_record(int ph, bit drain);
    int k, full, n, r;
    logic [7:0] rt;
    foreach (draft[i]) draft[i] = 8'($urandom_range(0, 255));
    k = $urandom_range(0, 7);
    case (k)
      0: begin
        rt = RT_SOLAR;
        full = 10;
        plant_pattern(16, 16); plant_pattern(32, 16);
        plant_pattern(48, 16); plant_pattern(64, 16);
      end
      1, 2: begin
        rt = RT_MONITOR;
        full = 15;
        plant_pattern(0, 16);  plant_pattern(16, 16); plant_pattern(48, 16);
        plant_pattern(66, 22); plant_pattern(88, 20); plant_pattern(108, 10);
      end
      3: begin
        rt = RT_INVERT;
        full = 11;
        plant_pattern(24, 16); plant_pattern(40, 16);
        plant_pattern(56, 15); plant_pattern(71, 11);
      end
      4: begin
        rt = RT_DCDC;
        full = 6;
        plant_pattern(16, 16); plant_pattern(32, 16);
      end
      5, 6: begin
        rt = RT_CHARGER;
        full = 12;
        plant_pattern(16, 13); plant_pattern(29, 11); plant_pattern(88, 7);
      end
      default: begin
        rt = 8'($urandom_range(0, 255));
        full = $urandom_range(1, 4);
      end
    endcase
    r = $urandom_range(0, 9);
    if (r == 0 && full > 1) n = $urandom_range(1, full - 1);
    else if (r == 1) n = $urandom_range(PAYLOAD_BYTES + 1, 20);
    else n = full;
    send_draft(n, rt, $urandom_range(0, 9) != 0, ph, drain);
  endfunction

  // ---------------- driver ----------------

  always @(negedge clk_i) begin : drive_b
    byte_item_t it;
    if (rst_ni) begin
      if (!in_if.valid || in_took) begin
        if (byte_q.size() != 0 && !(byte_q[0].drain && fields_due.size() != 0) &&
            $urandom_range(0, 99) >= idle_pct(byte_q[0].phase)) begin
          it = byte_q.pop_front();
          cur_phase         <= it.phase;
          in_if.first_byte  <= it.first;
          in_if.data_byte   <= it.data;
          in_if.last_byte   <= it.last;
          in_if.record_type <= it.rtype;
          in_if.valid       <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= $urandom_range(0, 99) >= stall_pct(cur_phase);
    end
  end

  // ---------------- monitor and checker ----------------

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i) begin : check_b
    field_t want;
    in_took <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (fields_due.size() == 0) begin
          note_failure($sformatf("unexpected field: code=%0d value=%0d valid=%0b last=%0b",
                                 out_if.field_code, out_if.field_value,
                                 out_if.field_valid, out_if.last_field));
        end else begin
          want = fields_due.pop_front();
          if (out_if.field_code !== want.code || out_if.field_value !== want.value ||
              out_if.field_valid !== want.ok || out_if.last_field !== want.last)
            note_failure($sformatf(
              "field exp code=%0d value=%0d valid=%0b last=%0b, got code=%0d value=%0d valid=%0b last=%0b",
              want.code, want.value, want.ok, want.last, out_if.field_code,
              out_if.field_value, out_if.field_valid, out_if.last_field));
        end
      end
      if (in_if.valid && in_if.ready) begin
        take_byte(in_if.first_byte, in_if.data_byte, in_if.last_byte, in_if.record_type);
        bytes_taken++;
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main_b
    int start;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.first_byte  = 1'b0;
    in_if.data_byte   = 8'h00;
    in_if.last_byte   = 1'b0;
    in_if.record_type = 8'h00;
    out_if.ready      = 1'b0;
    foreach (rec_bytes[i]) rec_bytes[i] = 8'h00;

    // unsupported types, the second one appended without a first mark
    put(1'b1, 8'h5A, 1'b1, 8'h00, 0, 1'b0);
    put(1'b0, 8'hA5, 1'b1, 8'hFF, 0, 1'b0);
    // solar: battV not available, battI most negative, yield and pvW not available
    draft[0] = 8'hFF; draft[1] = 8'h00; draft[2] = 8'hFF; draft[3] = 8'h7F;
    draft[4] = 8'h00; draft[5] = 8'h80; draft[6] = 8'hFF; draft[7] = 8'hFF;
    draft[8] = 8'hFF; draft[9] = 8'hFF;
    send_draft(10, RT_SOLAR, 1'b1, 0, 1'b0);
    // monitor cut short: remMin and battV not available, aux unused
    draft[0] = 8'hFF; draft[1] = 8'hFF; draft[2] = 8'hFF; draft[3] = 8'h7F;
    draft[4] = 8'hAA; draft[5] = 8'h55; draft[6] = 8'h34; draft[7] = 8'h12;
    draft[8] = 8'h03;
    send_draft(9, RT_MONITOR, 1'b1, 0, 1'b0);
    // byte without last mark
    put(1'b1, 8'h00, 1'b0, 8'h08, 0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      start = byte_q.size();
      gen_record(ph, ph != 0);
      while (byte_q.size() - start < 28) begin
        if ($urandom_range(0, 4) == 0)
          put(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), ph, 1'b0);
        else
          gen_record(ph, 1'b0);
      end
    end
    bytes_total = byte_q.size();

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken != bytes_total || fields_due.size() != 0) @(negedge clk_i);
    repeat (TAIL) @(negedge clk_i);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
